/* hw/rtl/chlg_pkg.sv */
// shared constants, types and control structs of the core hotplug load governor
package chlg_pkg;

    localparam int NUM_CORES  = 8;
    localparam int CORE_W     = 3;
    localparam int CNT_W      = CORE_W + 1;
    localparam int MASK_W     = 8;
    localparam int LOAD_W     = 7;
    localparam int TIME_W     = 32;
    localparam int PROD_W     = TIME_W + LOAD_W;
    localparam int LOAD_SCALE = 100;
    localparam int MIN_UP_MS  = 750;
    localparam int DEF_THRESH = 65;
    localparam int DIV_STEPS  = LOAD_W;
    localparam int STEP_W     = 3;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int MODE_W     = 2;

    localparam logic [MASK_W-1:0] FULL_MASK = MASK_W'((1 << NUM_CORES) - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE = 1'b1;

    localparam logic [MODE_W-1:0] LIM_ALL     = 2'd0;
    localparam logic [MODE_W-1:0] LIM_HALF    = 2'd1;
    localparam logic [MODE_W-1:0] LIM_QUARTER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_WALK,
        ST_SUM
    } t_state;

    typedef enum logic [1:0] {
        ACT_SUMMARY = 2'd0,
        ACT_UP      = 2'd1,
        ACT_DOWN    = 2'd2
    } t_action;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_step;
        logic update;
        logic walk_step;
        logic commit;
        logic summary;
    } t_cmd;

    typedef struct packed {
        logic    last;
        logic    walk_done;
        t_action act;
        logic    out_free;
    } t_status;

endpackage

/* hw/rtl/chlg_ctrl.sv */
// controller state machine: sequences multiply, divide, load update, decision walk and summary
module chlg_ctrl
    import chlg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = STEP_W'(DIV_STEPS - 1);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_UPD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.last ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                if (i_status.walk_done) begin
                    n_state = ST_SUM;
                end else if (i_status.act == ACT_SUMMARY) begin
                    o_cmd.walk_step = 1'b1;
                end else if (i_status.out_free) begin
                    // a change of the mask goes out as one item
                    o_cmd.walk_step = 1'b1;
                    o_cmd.commit    = 1'b1;
                end
            end
            ST_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.summary = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/chlg_dp.sv */
// datapath: config registers, load divider, per-core load and up-time state, output register
module chlg_dp
    import chlg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CORE_W-1:0]     i_core,
    input  logic [TIME_W-1:0]     i_wall,
    input  logic [TIME_W-1:0]     i_idle,
    input  logic [TIME_W-1:0]     i_time,
    input  logic                  i_last,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CORE_W-1:0]     o_out_core,
    output logic [1:0]            o_out_act,
    output logic [MASK_W-1:0]     o_out_mask,
    output logic                  o_out_last
);

    logic [LOAD_W-1:0]  r_thresh;
    logic [MODE_W-1:0]  r_mode;

    logic [CORE_W-1:0]  r_core;
    logic [TIME_W-1:0]  r_wall;
    logic [TIME_W-1:0]  r_idle;
    logic [TIME_W-1:0]  r_time;
    logic               r_last;

    logic [PROD_W-1:0]  r_rem;
    logic [PROD_W-1:0]  r_dsr;
    logic [LOAD_W-1:0]  r_quo;
    logic               r_zero;

    logic [MASK_W-1:0]  r_mask;
    logic [LOAD_W-1:0]  r_prev [NUM_CORES];
    logic [LOAD_W-1:0]  r_cur  [NUM_CORES];
    logic [TIME_W-1:0]  r_up   [NUM_CORES];

    logic [CNT_W-1:0]   r_walk;

    logic               r_out_valid;
    logic [CORE_W-1:0]  r_out_core;
    logic [1:0]         r_out_act;
    logic [MASK_W-1:0]  r_out_mask;
    logic               r_out_last;

    logic [PROD_W-1:0]  w_prod;
    logic               w_core_ok;
    logic [LOAD_W-1:0]  w_ld;
    logic [LOAD_W:0]    w_sum;
    logic [CNT_W-1:0]   w_limit;
    logic [CNT_W-1:0]   w_next;
    logic [CORE_W-1:0]  w_i;
    logic [CORE_W-1:0]  w_n;
    logic               w_on_i;
    logic               w_on_n;
    logic [LOAD_W-1:0]  w_cur_i;
    logic [TIME_W-1:0]  w_diff;
    logic               w_aged;
    t_action            w_act;
    logic               w_out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= LOAD_W'(DEF_THRESH);
            r_mode   <= LIM_ALL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD:  r_thresh <= i_cfg_data[LOAD_W-1:0];
                CFG_LIMIT_MODE: r_mode   <= i_cfg_data[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    // captured item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_core <= i_core;
            r_wall <= i_wall;
            r_idle <= i_idle;
            r_time <= i_time;
            r_last <= i_last;
        end
    end

    // load = 100*(wall-idle)/wall, restoring division, one quotient bit per cycle
    assign w_prod = PROD_W'(r_wall - r_idle) * PROD_W'(LOAD_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem  <= w_prod;
            r_dsr  <= PROD_W'(r_wall) << (DIV_STEPS - 1);
            r_quo  <= '0;
            r_zero <= !r_mask[r_core] || (r_wall == '0) || (r_idle > r_wall);
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_quo <= {r_quo[LOAD_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[LOAD_W-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    assign w_core_ok = CNT_W'(r_core) < CNT_W'(NUM_CORES);
    assign w_ld      = r_zero ? '0 : r_quo;
    assign w_sum     = {1'b0, w_ld} + {1'b0, r_prev[r_core]};

    // decision walk
    always_comb begin
        case (r_mode)
            LIM_HALF:    w_limit = CNT_W'(NUM_CORES / 2);
            LIM_QUARTER: w_limit = CNT_W'(NUM_CORES / 4);
            default:     w_limit = CNT_W'(NUM_CORES);
        endcase
    end

    assign w_next  = r_walk + 1'b1;
    assign w_i     = r_walk[CORE_W-1:0];
    assign w_n     = w_next[CORE_W-1:0];
    assign w_on_i  = r_mask[w_i];
    assign w_on_n  = r_mask[w_n];
    assign w_cur_i = r_cur[w_i];
    assign w_diff  = r_time - r_up[w_n];
    assign w_aged  = !w_diff[TIME_W-1] && (w_diff > TIME_W'(MIN_UP_MS));

    always_comb begin
        w_act = ACT_SUMMARY;
        // the last core has no next core to act on
        if (w_next < CNT_W'(NUM_CORES) && w_on_i) begin
            if (w_cur_i > r_thresh && !w_on_n) begin
                w_act = ACT_UP;
            end else if (w_cur_i < r_thresh && w_on_n && w_aged) begin
                w_act = ACT_DOWN;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // per-core state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= FULL_MASK;
            r_walk <= '0;
            for (int k = 0; k < NUM_CORES; k++) begin
                r_prev[k] <= '0;
                r_cur[k]  <= '0;
                r_up[k]   <= '0;
            end
        end else begin
            if (i_cmd.load_in) begin
                r_walk <= '0;
            end
            if (i_cmd.update && w_core_ok) begin
                r_cur[r_core]  <= w_sum[LOAD_W:1];
                r_prev[r_core] <= w_ld;
            end
            if (i_cmd.walk_step) begin
                r_walk <= w_next;
            end
            if (i_cmd.commit) begin
                if (w_act == ACT_UP) begin
                    r_mask[w_n] <= 1'b1;
                    r_up[w_n]   <= r_time;
                end else begin
                    r_mask[w_n] <= 1'b0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.summary) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_core <= w_n;
            r_out_act  <= w_act;
            r_out_mask <= (w_act == ACT_UP) ? (r_mask | (MASK_W'(1) << w_n))
                                            : (r_mask & ~(MASK_W'(1) << w_n));
            r_out_last <= 1'b0;
        end else if (i_cmd.summary) begin
            r_out_core <= '0;
            r_out_act  <= ACT_SUMMARY;
            r_out_mask <= r_mask;
            r_out_last <= 1'b1;
        end
    end

    assign o_status.last      = r_last;
    assign o_status.walk_done = r_walk >= w_limit;
    assign o_status.act       = w_act;
    assign o_status.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_core  = r_out_core;
    assign o_out_act   = r_out_act;
    assign o_out_mask  = r_out_mask;
    assign o_out_last  = r_out_last;

endmodule

/* hw/rtl/cpu_hotplug_load_governor.sv */
// top level of the core hotplug load governor
//
// Input stream: one item per core sample (core index, wall and idle deltas,
// millisecond time); tlast marks the final sample of a tick. Each sample
// updates that core's averaged load. The final sample also starts the
// decision walk over the cores the limit allows: every core brought up or taken down
// gives one output item, and a summary item with tlast high closes the tick.
// Config: write i_cfg_we with i_cfg_idx 0 (load threshold) or 1 (limit mode).
// Flow: a sample is taken in the idle state, then passes the multiply, the
// divider steps (one quotient bit per cycle) and the state update before
// the next sample is taken. A tick-closing sample then walks the cores in
// order (the last core has no next core), then leaves it and sends the summary.
// The output sits in a register; a stalled receiver holds the walk in place
// until that register frees, and the next sample is taken while the summary
// still waits. Reset marks all cores online, clears loads and up-times, and
// loads threshold 65 and limit mode 0.
module cpu_hotplug_load_governor
    import chlg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // core_index, wall_delta, idle_delta, time_ms, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // target_core, action, online_mask, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [CORE_W-1:0]  w_out_core;
    logic [1:0]         w_out_act;
    logic [MASK_W-1:0]  w_out_mask;

    chlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    chlg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_core      (s_axis_tdata[2:0]),
        .i_wall      (s_axis_tdata[34:3]),
        .i_idle      (s_axis_tdata[66:35]),
        .i_time      (s_axis_tdata[98:67]),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_core  (w_out_core),
        .o_out_act   (w_out_act),
        .o_out_mask  (w_out_mask),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_out_mask, w_out_act, w_out_core};

endmodule

/* sim/cpu_hotplug_load_governor_test.sv */
// self-checking testbench for the core hotplug load governor
`timescale 1ns / 100ps

module cpu_hotplug_load_governor_test;
    import chlg_pkg::*;

    localparam logic [MODE_W-1:0] LIM_RESERVED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_GAP   = 24;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic [CORE_W-1:0] target;
        t_action           act;
        logic [MASK_W-1:0] mask;
        logic              last;
    } t_gov_result;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        logic [CORE_W-1:0]     core;
        logic [TIME_W-1:0]     wall;
        logic [TIME_W-1:0]     idle;
        logic [TIME_W-1:0]     now;
        logic                  last;
        logic                  typed;
        logic [MASK_W-1:0]     typed_mask;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // core_index, wall_delta, idle_delta, time_ms, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // target_core, action, online_mask, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // governor copy kept by the testbench
    logic [MASK_W-1:0]     gov_online;
    logic [LOAD_W-1:0]     gov_prev [NUM_CORES];
    logic [LOAD_W-1:0]     gov_avg [NUM_CORES];
    logic [TIME_W-1:0]     gov_up [NUM_CORES];
    logic [LOAD_W-1:0]     gov_thresh;
    logic [MODE_W-1:0]     gov_mode;

    t_gov_result tick_results[$];
    t_gov_result expected_q[$];
    int          errors = 0;
    int          core_bias [NUM_CORES];
    bit          steady = 1'b0;
    int          hold_asked = 0;

    // kind, idx, value, core, wall, idle, time, last, typed, mask
    t_dir_row dir_rows [25] = '{
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd100, 32'd0, 32'd0, 1'b1, 1'b1, FULL_MASK},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd0, 32'd0, 32'd1000, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd1, 32'd10, 32'd20, 32'd1000, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd2, 32'hFFFF_FFFF, 32'd0, 32'd1000, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 1'b0, 1'b0,
          8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd5, 32'd3, 32'd1, 32'd1000, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd7, 32'h7FFF_FFFF, 32'd0, 32'd1000, 1'b1, 1'b0, 8'd0},
        '{ROW_CFG, CFG_THRESHOLD, 7'd0, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd1000, 32'd1, 32'd1100, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd6, 32'd1000, 32'd1, 32'd1100, 1'b1, 1'b0, 8'd0},
        '{ROW_CFG, CFG_THRESHOLD, 7'd127, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd50, 32'd25, 32'hFFFF_FF00, 1'b1, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd50, 32'd0, 32'h0000_0100, 1'b1, 1'b0, 8'd0},
        '{ROW_CFG, CFG_LIMIT_MODE, {5'd0, LIM_HALF}, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
          8'd0},
        '{ROW_CFG, CFG_THRESHOLD, 7'd11, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd9, 32'd0, 32'h8000_0500, 1'b1, 1'b0, 8'd0},
        '{ROW_CFG, CFG_LIMIT_MODE, {5'd0, LIM_QUARTER}, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
          8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd1, 32'd100, 32'd50, 32'h8000_1000, 1'b1, 1'b0, 8'd0},
        '{ROW_CFG, CFG_LIMIT_MODE, {5'd0, LIM_RESERVED}, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0,
          1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd0, 32'd100, 32'd0, 32'h8000_1400, 1'b0, 1'b0, 8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          1'b0, 8'd0},
        '{ROW_CFG, CFG_THRESHOLD, 7'd100, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0},
        '{ROW_CFG, CFG_LIMIT_MODE, {5'd0, LIM_ALL}, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
          8'd0},
        '{ROW_SAMPLE, 1'b0, 7'd0, 3'd4, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0,
          8'd0},
        '{ROW_CFG, CFG_THRESHOLD, 7'(DEF_THRESH), 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0}
    };

    cpu_hotplug_load_governor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // fills tick_results with what one sample causes
    function automatic void govern_sample(input logic [CORE_W-1:0] core,
                                          input logic [TIME_W-1:0] wall,
                                          input logic [TIME_W-1:0] idle,
                                          input logic [TIME_W-1:0] now,
                                          input logic last);
        longint unsigned busy;
        logic [LOAD_W-1:0] ld;
        logic [LOAD_W:0]   sum;
        logic [TIME_W-1:0] diff;
        int limit;
        int i;
        int nxt;
        tick_results.delete();
        ld = '0;
        if (gov_online[core] && wall != 0 && idle <= wall) begin
            busy = (longint'(wall) - longint'(idle)) * LOAD_SCALE;
            ld = LOAD_W'(busy / longint'(wall));
        end
        sum = {1'b0, ld} + {1'b0, gov_prev[core]};
        gov_avg[core] = sum[LOAD_W:1];
        gov_prev[core] = ld;
        if (!last) return;
        if (gov_mode == LIM_HALF) begin
            limit = NUM_CORES / 2;
        end else if (gov_mode == LIM_QUARTER) begin
            limit = NUM_CORES / 4;
        end else begin
            limit = NUM_CORES;
        end
        for (i = 0; i < limit; i++) begin
            nxt = i + 1;
            if (nxt >= NUM_CORES || !gov_online[i]) continue;
            if (gov_avg[i] > gov_thresh && !gov_online[nxt]) begin
                gov_up[nxt] = now;
                gov_online[nxt] = 1'b1;
                tick_results.push_back('{CORE_W'(nxt), ACT_UP, gov_online, 1'b0});
            end else if (gov_avg[i] < gov_thresh && gov_online[nxt]) begin
                diff = now - gov_up[nxt];
                // wrapped difference read as signed, must exceed the minimum up-time
                if (!diff[TIME_W-1] && diff > MIN_UP_MS) begin
                    gov_online[nxt] = 1'b0;
                    tick_results.push_back('{CORE_W'(nxt), ACT_DOWN, gov_online, 1'b0});
                end
            end
        end
        tick_results.push_back('{'0, ACT_SUMMARY, gov_online, 1'b1});
    endfunction

    task automatic offer_sample(input logic [CORE_W-1:0] core, input logic [TIME_W-1:0] wall,
                                input logic [TIME_W-1:0] idle, input logic [TIME_W-1:0] now,
                                input logic last, input logic typed,
                                input logic [MASK_W-1:0] typed_mask);
        if (!steady && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({now, idle, wall, core});
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        govern_sample(core, wall, idle, now, last);
        if (typed) begin
            expected_q.push_back('{'0, ACT_SUMMARY, typed_mask, 1'b1});
        end else begin
            foreach (tick_results[k]) expected_q.push_back(tick_results[k]);
        end
    endtask

    // sender pauses until every expected item is back and the block has gone quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD) begin
            gov_thresh = val;
        end else begin
            gov_mode = val[MODE_W-1:0];
        end
    endtask

    // per-core load drifts so averages cross the threshold now and then
    task automatic draw_sample(input int core, output logic [TIME_W-1:0] wall,
                               output logic [TIME_W-1:0] idle);
        int r;
        int pct;
        r = $urandom_range(0, 19);
        core_bias[core] = core_bias[core] + $urandom_range(0, 40) - 20;
        if (core_bias[core] < 0) core_bias[core] = 0;
        if (core_bias[core] > 100) core_bias[core] = 100;
        if (r == 0) begin
            wall = '0;
            idle = $urandom();
        end else if (r == 1) begin
            wall = $urandom();
            idle = $urandom();
        end else if (r == 2) begin
            wall = $urandom_range(1, 100000);
            idle = wall + $urandom_range(1, 100);
        end else begin
            wall = (r < 8) ? $urandom() : $urandom_range(1, 100000);
            if (wall == 0) wall = 1;
            pct = core_bias[core] + $urandom_range(0, 10) - 5;
            if (pct < 0) pct = 0;
            if (pct > 100) pct = 100;
            idle = wall - TIME_W'((longint'(wall) * pct) / 100);
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin : drive_ready
        int hold_left;
        int hold_taken;
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_taken) begin
            hold_taken++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    initial begin : drive_ready_init
        drive_ready.hold_left = 0;
        drive_ready.hold_taken = 0;
    end

    always @(posedge i_clk) begin : check_results
        t_gov_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item, tdata", m_axis_tdata, 0);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[2:0] !== want.target)
                    report_mismatch("target_core", m_axis_tdata[2:0], want.target);
                if (m_axis_tdata[4:3] !== want.act)
                    report_mismatch("action", m_axis_tdata[4:3], want.act);
                if (m_axis_tdata[12:5] !== want.mask)
                    report_mismatch("online_mask", m_axis_tdata[12:5], want.mask);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] wall;
        logic [TIME_W-1:0] idle;
        bit   pick [NUM_CORES];
        bit   held;
        bit   paused;
        int   sent;
        int   next_cfg;
        int   kind;
        int   final_core;
        int   noise_n;
        int   waited;
        int   r;

        gov_online = FULL_MASK;
        gov_thresh = LOAD_W'(DEF_THRESH);
        gov_mode   = LIM_ALL;
        for (r = 0; r < NUM_CORES; r++) begin
            gov_prev[r]  = '0;
            gov_avg[r]   = '0;
            gov_up[r]    = '0;
            core_bias[r] = $urandom_range(0, 100);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
            end else begin
                offer_sample(dir_rows[k].core, dir_rows[k].wall, dir_rows[k].idle,
                             dir_rows[k].now, dir_rows[k].last, dir_rows[k].typed,
                             dir_rows[k].typed_mask);
            end
        end

        now = $urandom();
        sent = 0;
        next_cfg = 60;
        held = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_cfg) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    write_reg(CFG_THRESHOLD, $urandom_range(0, 1) ? 7'd127 : 7'd0);
                end else if (r == 1) begin
                    write_reg(CFG_THRESHOLD, $urandom_range(0, 1) ? 7'd100 : 7'd11);
                end else begin
                    write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(30, 90)));
                end
                write_reg(CFG_LIMIT_MODE, CFG_DATA_W'($urandom_range(0, 3)));
                next_cfg += 60;
            end
            if (!held && sent >= 40) begin
                hold_asked++;
                held = 1'b1;
            end
            if (!paused && sent >= 120) begin
                s_axis_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
                paused = 1'b1;
            end
            steady = (sent >= 180 && sent < 250);

            if ($urandom_range(0, 24) == 0) begin
                now = $urandom();
            end else begin
                now = now + $urandom_range(0, 500);
            end

            kind = $urandom_range(0, 9);
            if (kind <= 8) begin
                // ascending samples, full tick or a subset with stale cores
                final_core = -1;
                for (r = 0; r < NUM_CORES; r++) begin
                    pick[r] = (kind <= 6) || ($urandom_range(0, 1) == 1);
                    if (pick[r]) final_core = r;
                end
                if (final_core < 0) begin
                    final_core = $urandom_range(0, NUM_CORES - 1);
                    pick[final_core] = 1'b1;
                end
                for (r = 0; r < NUM_CORES; r++) begin
                    if (pick[r]) begin
                        draw_sample(r, wall, idle);
                        offer_sample(CORE_W'(r), wall, idle, now, r == final_core, 1'b0, '0);
                        sent++;
                    end
                end
            end else begin
                // out-of-order cores with random tick marks
                noise_n = $urandom_range(1, 4);
                for (r = 0; r < noise_n; r++) begin
                    kind = $urandom_range(0, NUM_CORES - 1);
                    draw_sample(kind, wall, idle);
                    offer_sample(CORE_W'(kind), wall, idle, now, 1'($urandom_range(0, 1)),
                                 1'b0, '0);
                    sent++;
                end
            end
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_q.size() != 0)
            report_mismatch("items still expected at end", expected_q.size(), 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("cpu_hotplug_load_governor regression: pass");
        end else begin
            $display("cpu_hotplug_load_governor regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("cpu_hotplug_load_governor regression: fail");
        $finish;
    end

endmodule

/* cpu_hotplug_load_governor.f */
hw/rtl/chlg_pkg.sv
hw/rtl/chlg_ctrl.sv
hw/rtl/chlg_dp.sv
hw/rtl/cpu_hotplug_load_governor.sv
sim/cpu_hotplug_load_governor_test.sv
